// ----- rtl/core/sle_pkg.sv -----
// Shared types, byte codes and default sizes for the serial line editor.
package sle_pkg;

  localparam int LINE_BYTES_DEF = 64;
  localparam int HIST_DEPTH_DEF = 4;
  localparam int HIST_ENTRY_DEF = 64;

  localparam int BYTE_W    = 8;
  localparam int SLOT_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RAW_PREFIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_SLOTS = 2'd1;

  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_UP    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_DOWN  = 8'h42;
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h43;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h44;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_NORMAL   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RAW      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // What an accepted byte asks of the sequencer.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_DELETE,
    ACT_RECALL,
    ACT_PUSH,
    ACT_EMIT,
    ACT_STATUS
  } act_t;

  // Datapath operation for the current cycle.
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_ACCEPT,
    STEP_SH_RD,
    STEP_SH_WR,
    STEP_SH_FIN,
    STEP_DL_RD,
    STEP_DL_WR,
    STEP_DL_FIN,
    STEP_RC_RD,
    STEP_RC_WR,
    STEP_RC_FIN,
    STEP_PU_RD,
    STEP_PU_WR,
    STEP_EM_START,
    STEP_EM_RD,
    STEP_EM_LD
  } step_t;

  typedef struct packed {
    step_t step;
    logic  status_load;
  } sle_cmd_t;

  typedef struct packed {
    act_t act;
    logic sh_more;
    logic dl_more;
    logic cp_more;
    logic em_last;
    logic out_free;
  } sle_stat_t;

endpackage

// ----- rtl/core/sle_if.sv -----
// Request channel interfaces for received bytes and finished line items.
interface sle_in_if import sle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sle_out_if import sle_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                has_byte;
  logic [STATUS_W-1:0] line_status;
  logic                line_last;
  modport source (output valid, output out_byte, output has_byte, output line_status,
                  output line_last, input ready);
  modport sink (input valid, input out_byte, input has_byte, input line_status,
                input line_last, output ready);
endinterface

// ----- rtl/core/sle_ctrl.sv -----
// Sequencer state machine for the serial line editor.
module sle_ctrl import sle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sle_stat_t stat,
  output sle_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SH_RD = 12'b000000000010,
    S_SH_WR = 12'b000000000100,
    S_DL_RD = 12'b000000001000,
    S_DL_WR = 12'b000000010000,
    S_RC_RD = 12'b000000100000,
    S_RC_WR = 12'b000001000000,
    S_PU_RD = 12'b000010000000,
    S_PU_WR = 12'b000100000000,
    S_EM_RD = 12'b001000000000,
    S_EM_WR = 12'b010000000000,
    S_ST    = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmd.step        = STEP_NONE;
    cmd.status_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step = STEP_ACCEPT;
          case (stat.act)
            ACT_INSERT: state_nxt = S_SH_RD;
            ACT_DELETE: state_nxt = S_DL_RD;
            ACT_RECALL: state_nxt = S_RC_RD;
            ACT_PUSH:   state_nxt = S_PU_RD;
            ACT_EMIT:   state_nxt = S_EM_RD;
            ACT_STATUS: state_nxt = S_ST;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_SH_RD: begin
        if (stat.sh_more) begin
          cmd.step  = STEP_SH_RD;
          state_nxt = S_SH_WR;
        end else begin
          cmd.step  = STEP_SH_FIN;
          state_nxt = S_IDLE;
        end
      end
      S_SH_WR: begin
        cmd.step  = STEP_SH_WR;
        state_nxt = S_SH_RD;
      end
      S_DL_RD: begin
        if (stat.dl_more) begin
          cmd.step  = STEP_DL_RD;
          state_nxt = S_DL_WR;
        end else begin
          cmd.step  = STEP_DL_FIN;
          state_nxt = S_IDLE;
        end
      end
      S_DL_WR: begin
        cmd.step  = STEP_DL_WR;
        state_nxt = S_DL_RD;
      end
      S_RC_RD: begin
        if (stat.cp_more) begin
          cmd.step  = STEP_RC_RD;
          state_nxt = S_RC_WR;
        end else begin
          cmd.step  = STEP_RC_FIN;
          state_nxt = S_IDLE;
        end
      end
      S_RC_WR: begin
        cmd.step  = STEP_RC_WR;
        state_nxt = S_RC_RD;
      end
      S_PU_RD: begin
        if (stat.cp_more) begin
          cmd.step  = STEP_PU_RD;
          state_nxt = S_PU_WR;
        end else begin
          cmd.step  = STEP_EM_START;
          state_nxt = S_EM_RD;
        end
      end
      S_PU_WR: begin
        cmd.step  = STEP_PU_WR;
        state_nxt = S_PU_RD;
      end
      S_EM_RD: begin
        cmd.step  = STEP_EM_RD;
        state_nxt = S_EM_WR;
      end
      S_EM_WR: begin
        if (stat.out_free) begin
          cmd.step  = STEP_EM_LD;
          state_nxt = stat.em_last ? S_IDLE : S_EM_RD;
        end
      end
      S_ST: begin
        if (stat.out_free) begin
          cmd.status_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/sle_dpath.sv -----
// Line buffer, history ring, edit registers and output register of the line editor.
module sle_dpath import sle_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  parameter int HIST_DEPTH = HIST_DEPTH_DEF,
  parameter int HIST_ENTRY = HIST_ENTRY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 out_ready,
  input  sle_cmd_t             cmd,
  output sle_stat_t            stat,
  output logic                 out_valid,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_has_byte,
  output logic [STATUS_W-1:0]  out_line_status,
  output logic                 out_line_last
);

  localparam int LEN_W  = $clog2(LINE_BYTES);
  localparam int HL_W   = $clog2(HIST_ENTRY);
  localparam int IX_W   = (LEN_W > HL_W) ? LEN_W : HL_W;
  localparam int HS_W   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int HDEPTH = HIST_DEPTH * HIST_ENTRY;
  localparam int HA_W   = $clog2(HDEPTH);

  logic [BYTE_W-1:0] line_mem [LINE_BYTES];
  logic [BYTE_W-1:0] hist_mem [HDEPTH];
  logic [HL_W-1:0]   hlen_r [HIST_DEPTH];

  logic [LEN_W-1:0]    len_r, len_nxt, pos_r, pos_nxt;
  logic                ovf_r, ovf_nxt, raw_r, raw_nxt, cr_r, cr_nxt;
  logic [1:0]          esc_r, esc_nxt;
  logic [BYTE_W-1:0]   prefix_r, prefix_nxt, byte_r, byte_nxt;
  logic [SLOT_W-1:0]   slots_r, slots_nxt, head_r, head_nxt, count_r, count_nxt;
  logic [SLOT_W-1:0]   browse_r, browse_nxt, slot_r, slot_nxt;
  logic [IX_W-1:0]     idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic                ov_r, ov_nxt, oh_r, oh_nxt, ol_r, ol_nxt;
  logic [BYTE_W-1:0]   ob_r, ob_nxt;
  logic [STATUS_W-1:0] os_r, os_nxt;

  logic [BYTE_W-1:0] lrdata_r, hrdata_r;
  logic              lrd_en, lwr_en, hrd_en, hwr_en, hlen_we;
  logic [LEN_W-1:0]  lrd_addr, lwr_addr;
  logic [BYTE_W-1:0] lwr_data;
  logic [HA_W-1:0]   hist_addr;
  logic [HL_W-1:0]   hlen_wdata;

  logic [SLOT_W-1:0] d_use, cnt_use, np, rslot;
  logic [IX_W-1:0]   rlen, plen, len_x, pos_x;
  logic              out_free, clear;

  assign d_use   = ({1'b0, slots_r} > (SLOT_W+1)'(HIST_DEPTH)) ? SLOT_W'(HIST_DEPTH) : slots_r;
  assign cnt_use = (count_r > d_use) ? d_use : count_r;
  assign len_x   = IX_W'(len_r);
  assign pos_x   = IX_W'(pos_r);
  assign rlen    = (IX_W'(hlen_r[rslot[HS_W-1:0]]) > IX_W'(LINE_BYTES - 1)) ?
                   IX_W'(LINE_BYTES - 1) : IX_W'(hlen_r[rslot[HS_W-1:0]]);
  assign plen    = (len_x > IX_W'(HIST_ENTRY - 1)) ? IX_W'(HIST_ENTRY - 1) : len_x;
  assign hist_addr = HA_W'(slot_r[HS_W-1:0]) * HA_W'(HIST_ENTRY) + HA_W'(idx_r);
  assign out_free  = !ov_r || out_ready;

  always_comb begin
    np = '0;
    if (rx_byte == CH_UP) begin
      np = browse_r + 1'b1;
    end else begin
      np = browse_r - 1'b1;
    end
    if (head_r >= np) begin
      rslot = head_r - np;
    end else begin
      rslot = head_r + d_use - np;
    end
  end

  always_comb begin
    stat.act      = ACT_NONE;
    stat.sh_more  = idx_r > pos_x;
    stat.dl_more  = idx_r < len_x;
    stat.cp_more  = idx_r < cnt_r;
    stat.em_last  = (idx_r + 1'b1) == len_x;
    stat.out_free = out_free;

    len_nxt = len_r;  pos_nxt = pos_r;  ovf_nxt = ovf_r;  raw_nxt = raw_r;
    cr_nxt = cr_r;    esc_nxt = esc_r;  prefix_nxt = prefix_r;
    byte_nxt = byte_r; slots_nxt = slots_r; head_nxt = head_r; count_nxt = count_r;
    browse_nxt = browse_r; slot_nxt = slot_r; idx_nxt = idx_r; cnt_nxt = cnt_r;
    ov_nxt = out_ready ? 1'b0 : ov_r;
    ob_nxt = ob_r; oh_nxt = oh_r; os_nxt = os_r; ol_nxt = ol_r;
    lrd_en = 1'b0; lrd_addr = idx_r[LEN_W-1:0];
    lwr_en = 1'b0; lwr_addr = idx_r[LEN_W-1:0]; lwr_data = lrdata_r;
    hrd_en = 1'b0; hwr_en = 1'b0; hlen_we = 1'b0; hlen_wdata = HL_W'(plen);
    clear = 1'b0;

    // Decode of the accepted byte.
    if (rx_byte == CH_LF && cr_r) begin
      cr_nxt = 1'b0;
    end else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
      cr_nxt  = (rx_byte == CH_CR);
      esc_nxt = ESC_NONE;
      idx_nxt = '0;
      if (ovf_r || len_r == '0) begin
        stat.act = ACT_STATUS;
      end else if (!raw_r && d_use != '0) begin
        stat.act  = ACT_PUSH;
        slot_nxt  = head_r;
        cnt_nxt   = plen;
        hlen_we   = (cmd.step == STEP_ACCEPT);
        head_nxt  = (head_r + 1'b1 == d_use) ? '0 : head_r + 1'b1;
        count_nxt = (count_r < d_use) ? count_r + 1'b1 : d_use;
      end else begin
        stat.act = ACT_EMIT;
      end
    end else begin
      cr_nxt = 1'b0;
      if (esc_r == ESC_CSI) begin
        esc_nxt = ESC_NONE;
        if (rx_byte == CH_LEFT) begin
          if (pos_r != '0) pos_nxt = pos_r - 1'b1;
        end else if (rx_byte == CH_RIGHT) begin
          if (pos_r < len_r) pos_nxt = pos_r + 1'b1;
        end else if (rx_byte == CH_UP || rx_byte == CH_DOWN) begin
          if (d_use != '0 && cnt_use != '0 &&
              ((rx_byte == CH_UP && browse_r < cnt_use) ||
               (rx_byte == CH_DOWN && browse_r != '0))) begin
            browse_nxt = np;
            if (np == '0) begin
              len_nxt = '0;
              pos_nxt = '0;
            end else begin
              stat.act = ACT_RECALL;
              slot_nxt = rslot;
              cnt_nxt  = rlen;
              idx_nxt  = '0;
            end
          end
        end
      end else if (esc_r == ESC_SEEN) begin
        esc_nxt = (rx_byte == CH_LBRK) ? ESC_CSI : ESC_NONE;
      end else if (rx_byte == CH_ESC) begin
        esc_nxt = ESC_SEEN;
      end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
        if (pos_r != '0) begin
          stat.act = ACT_DELETE;
          idx_nxt  = pos_x;
        end
      end else if (rx_byte >= CH_SPACE) begin
        if (len_r == '0 && prefix_r != '0 && rx_byte == prefix_r) raw_nxt = 1'b1;
        if (len_x == IX_W'(LINE_BYTES - 1)) begin
          ovf_nxt = 1'b1;
        end else begin
          stat.act = ACT_INSERT;
          byte_nxt = rx_byte;
          idx_nxt  = len_x;
        end
      end
    end

    // Only the accept step keeps the decoded updates.
    if (cmd.step != STEP_ACCEPT) begin
      len_nxt = len_r;  pos_nxt = pos_r;  ovf_nxt = ovf_r;  raw_nxt = raw_r;
      cr_nxt = cr_r;    esc_nxt = esc_r;  byte_nxt = byte_r; head_nxt = head_r;
      count_nxt = count_r; browse_nxt = browse_r; slot_nxt = slot_r;
      idx_nxt = idx_r;  cnt_nxt = cnt_r;
    end

    case (cmd.step)
      STEP_SH_RD: begin
        lrd_en   = 1'b1;
        lrd_addr = LEN_W'(idx_r - 1'b1);
      end
      STEP_SH_WR: begin
        lwr_en  = 1'b1;
        idx_nxt = idx_r - 1'b1;
      end
      STEP_SH_FIN: begin
        lwr_en   = 1'b1;
        lwr_addr = pos_r;
        lwr_data = byte_r;
        len_nxt  = len_r + 1'b1;
        pos_nxt  = pos_r + 1'b1;
      end
      STEP_DL_RD: lrd_en = 1'b1;
      STEP_DL_WR: begin
        lwr_en   = 1'b1;
        lwr_addr = LEN_W'(idx_r - 1'b1);
        idx_nxt  = idx_r + 1'b1;
      end
      STEP_DL_FIN: begin
        len_nxt = len_r - 1'b1;
        pos_nxt = pos_r - 1'b1;
      end
      STEP_RC_RD: hrd_en = 1'b1;
      STEP_RC_WR: begin
        lwr_en   = 1'b1;
        lwr_data = hrdata_r;
        idx_nxt  = idx_r + 1'b1;
      end
      STEP_RC_FIN: begin
        len_nxt = LEN_W'(cnt_r);
        pos_nxt = LEN_W'(cnt_r);
      end
      STEP_PU_RD: lrd_en = 1'b1;
      STEP_PU_WR: begin
        hwr_en  = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      STEP_EM_START: idx_nxt = '0;
      STEP_EM_RD: lrd_en = 1'b1;
      STEP_EM_LD: begin
        ov_nxt  = 1'b1;
        ob_nxt  = lrdata_r;
        oh_nxt  = 1'b1;
        os_nxt  = raw_r ? ST_RAW : ST_NORMAL;
        ol_nxt  = stat.em_last;
        idx_nxt = idx_r + 1'b1;
        clear   = stat.em_last;
      end
      default: ;
    endcase

    if (cmd.status_load) begin
      ov_nxt = 1'b1;
      ob_nxt = '0;
      oh_nxt = 1'b0;
      os_nxt = ovf_r ? ST_OVERFLOW : ST_EMPTY;
      ol_nxt = 1'b1;
      clear  = 1'b1;
    end

    if (clear) begin
      len_nxt = '0; pos_nxt = '0; ovf_nxt = 1'b0; raw_nxt = 1'b0;
      esc_nxt = ESC_NONE; browse_nxt = '0;
    end

    if (cfg_we) begin
      if (cfg_index == CFG_RAW_PREFIX) begin
        prefix_nxt = cfg_wdata;
      end else if (cfg_index == CFG_HISTORY_SLOTS) begin
        slots_nxt  = cfg_wdata[SLOT_W-1:0];
        head_nxt   = '0;
        count_nxt  = '0;
        browse_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lwr_en) line_mem[lwr_addr] <= lwr_data;
    if (lrd_en) lrdata_r <= line_mem[lrd_addr];
  end

  always_ff @(posedge clk) begin
    if (hwr_en) hist_mem[hist_addr] <= lrdata_r;
    if (hrd_en) hrdata_r <= hist_mem[hist_addr];
    if (hlen_we) hlen_r[head_r[HS_W-1:0]] <= hlen_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; pos_r <= '0; ovf_r <= 1'b0; raw_r <= 1'b0; cr_r <= 1'b0;
      esc_r <= ESC_NONE; prefix_r <= '0; slots_r <= SLOT_W'(4);
      head_r <= '0; count_r <= '0; browse_r <= '0; ov_r <= 1'b0;
    end else begin
      len_r <= len_nxt; pos_r <= pos_nxt; ovf_r <= ovf_nxt; raw_r <= raw_nxt;
      cr_r <= cr_nxt; esc_r <= esc_nxt; prefix_r <= prefix_nxt; slots_r <= slots_nxt;
      head_r <= head_nxt; count_r <= count_nxt; browse_r <= browse_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt; slot_r <= slot_nxt; idx_r <= idx_nxt; cnt_r <= cnt_nxt;
    ob_r <= ob_nxt; oh_r <= oh_nxt; os_r <= os_nxt; ol_r <= ol_nxt;
  end

  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_has_byte    = oh_r;
  assign out_line_status = os_r;
  assign out_line_last   = ol_r;

endmodule

// ----- rtl/core/serial_line_editor.sv -----
// Top level of the serial line editor: byte in, finished line items out.
//
// Usage: received bytes arrive as requests on in_ch (rx_byte). The block edits a
// line buffer: printable bytes insert at the cursor, backspace and DEL delete to
// the left, ESC [ C / D move the cursor and ESC [ A / B recall history lines.
// CR or LF (CRLF counts once) ends the line; the line bytes then leave on out_ch
// one request each, or a single status request for an overflowed or empty line.
// A byte that only changes registers is done in the idle state. An insert or
// delete moves the tail through the line memory one byte at a time, with a
// read state and a write state per byte; a recall copies the history entry
// into the line buffer the same way. A line end that goes into history (not raw,
// history slots nonzero) first copies the line into the history memory, then
// reads and sends each line byte in turn.
// A new byte is taken only when the previous one is fully processed; the last
// result may still sit in the output register while the next byte is taken.
// Reset clears the line, cursor, flags, history pointers and the output
// valid flag; raw_prefix resets to zero and history_slots to four. No clearing
// pass is needed. When the receiver stalls, out_ch holds its request and the
// sequencer waits before loading the next line byte.
module serial_line_editor import sle_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  parameter int HIST_DEPTH = HIST_DEPTH_DEF,
  parameter int HIST_ENTRY = HIST_ENTRY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sle_in_if.sink               in_ch,
  sle_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  sle_cmd_t  cmd;
  sle_stat_t stat;

  // The controller owns sequencing; in_ch.ready is high only between bytes.
  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the memories, edit registers and output register.
  sle_dpath #(
    .LINE_BYTES (LINE_BYTES),
    .HIST_DEPTH (HIST_DEPTH),
    .HIST_ENTRY (HIST_ENTRY)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .rx_byte         (in_ch.rx_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_ready       (out_ch.ready),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_byte        (out_ch.out_byte),
    .out_has_byte    (out_ch.has_byte),
    .out_line_status (out_ch.line_status),
    .out_line_last   (out_ch.line_last)
  );

endmodule

// ----- test/serial_line_editor_tb.sv -----
// Testbench for the serial line editor: predicts line output and checks every item.
module serial_line_editor_tb;
  import sle_pkg::*;

  localparam int LSZ = LINE_BYTES_DEF;
  localparam int HDP = HIST_DEPTH_DEF;
  localparam int HEN = HIST_ENTRY_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] ob;
    logic       hb;
    logic [1:0] st;
    logic       last;
  } line_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0] cfg_wdata = '0;

  sle_in_if in_ch ();
  sle_out_if out_ch ();

  serial_line_editor dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the editor state; the config registers are kept at the block's own widths.
  logic [7:0] pfx_reg;
  logic [2:0] slots_reg;
  logic [7:0] line_buf [LSZ];
  int unsigned len_q, cur_q, head_q, cnt_q, brw_q;
  logic ovf_q, raw_q, cr_q;
  logic [1:0] esc_q;
  logic [7:0] hist_buf [HDP*HEN];
  int unsigned hist_len [HDP];

  line_item_t expected_items [$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int unsigned slots_used();
    return (slots_reg > HDP) ? HDP : slots_reg;
  endfunction

  function automatic void reset_model();
    pfx_reg = 8'h00; slots_reg = 3'd4;
    len_q = 0; cur_q = 0; ovf_q = 0; raw_q = 0; esc_q = ESC_NONE; brw_q = 0;
    cr_q = 0; head_q = 0; cnt_q = 0;
  endfunction

  function automatic void recall_line(input bit older);
    int unsigned d, c, np, sl, n;
    d = slots_used(); c = cnt_q;
    if (d == 0 || c == 0) return;
    if (c > d) c = d;
    if (older) begin
      if (brw_q >= c) return;
      np = brw_q + 1;
    end else begin
      if (brw_q == 0) return;
      np = brw_q - 1;
    end
    n = 0;
    if (np != 0) begin
      sl = ((head_q % d) + d - np) % d;
      n = hist_len[sl];
      if (n >= LSZ) n = LSZ - 1;
      if (n >= HEN) n = HEN - 1;
      for (int i = 0; i < n; i++) line_buf[i] = hist_buf[sl*HEN + i];
    end
    len_q = n; cur_q = n; brw_q = np;
  endfunction

  function automatic void finish_line();
    int unsigned d, n, sl;
    line_item_t it;
    if (ovf_q) begin
      it = '{8'h00, 1'b0, ST_OVERFLOW, 1'b1}; expected_items.push_back(it);
    end else if (len_q == 0) begin
      it = '{8'h00, 1'b0, ST_EMPTY, 1'b1}; expected_items.push_back(it);
    end else begin
      d = slots_used();
      if (!raw_q && d != 0) begin
        n = (len_q >= HEN) ? HEN - 1 : len_q;
        sl = head_q % d;
        for (int i = 0; i < n; i++) hist_buf[sl*HEN + i] = line_buf[i];
        hist_len[sl] = n;
        head_q = (sl + 1) % d;
        if (cnt_q < d) cnt_q++; else cnt_q = d;
      end
      for (int i = 0; i < len_q; i++) begin
        it = '{line_buf[i], 1'b1, raw_q ? ST_RAW : ST_NORMAL, (i + 1 == len_q)};
        expected_items.push_back(it);
      end
    end
    len_q = 0; cur_q = 0; ovf_q = 0; raw_q = 0; esc_q = ESC_NONE; brw_q = 0;
  endfunction

  // Applies one received byte to the shadow state and queues the items it causes.
  function automatic void predict_byte(input logic [7:0] c);
    if (c == CH_LF && cr_q) begin
      cr_q = 0; return;
    end
    if (c == CH_CR || c == CH_LF) begin
      cr_q = (c == CH_CR); esc_q = ESC_NONE; finish_line(); return;
    end
    cr_q = 0;
    if (esc_q == ESC_CSI) begin
      esc_q = ESC_NONE;
      case (c)
        CH_LEFT: begin if (cur_q > 0) cur_q--; end
        CH_RIGHT: begin if (cur_q < len_q) cur_q++; end
        CH_UP: recall_line(1);
        CH_DOWN: recall_line(0);
        default: ;
      endcase
      return;
    end
    if (esc_q == ESC_SEEN) begin
      esc_q = (c == CH_LBRK) ? ESC_CSI : ESC_NONE; return;
    end
    if (c == CH_ESC) begin
      esc_q = ESC_SEEN; return;
    end
    if (c == CH_BS || c == CH_DEL) begin
      if (cur_q != 0) begin
        for (int i = cur_q; i < len_q; i++) line_buf[i-1] = line_buf[i];
        len_q--; cur_q--;
      end
      return;
    end
    if (c < CH_SPACE) return;
    if (len_q == 0 && pfx_reg != 0 && c == pfx_reg) raw_q = 1;
    if (len_q + 1 >= LSZ) begin
      ovf_q = 1; return;
    end
    for (int i = len_q; i > cur_q; i--) line_buf[i] = line_buf[i-1];
    line_buf[cur_q] = c; len_q++; cur_q++;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sends one byte as a request and updates the prediction when it is taken.
  // Valid stays high after the edge that takes the byte; the next call either
  // drives a new byte at once or drops valid for its gap.
  task automatic send_byte(input logic [7:0] b);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(b);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Waits for all predicted items, then lets the last byte's processing settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (3 * LSZ + 20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RAW_PREFIX) pfx_reg = v;
    else if (idx == CFG_HISTORY_SLOTS) begin
      slots_reg = v[2:0]; head_q = 0; cnt_q = 0; brw_q = 0;
    end
  endtask

  // Receiver with random stalls, now and then a long one; each accepted item
  // is checked against the queue.
  always @(posedge clk) begin
    line_item_t got, exp_it;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_byte, out_ch.has_byte, out_ch.line_status, out_ch.line_last};
        if (expected_items.size() == 0)
          report_mismatch($sformatf("unexpected item %h", got));
        else begin
          exp_it = expected_items.pop_front();
          if (got.ob !== exp_it.ob)
            report_mismatch($sformatf("out_byte %h want %h", got.ob, exp_it.ob));
          if (got.hb !== exp_it.hb)
            report_mismatch($sformatf("has_byte %b want %b", got.hb, exp_it.hb));
          if (got.st !== exp_it.st)
            report_mismatch($sformatf("line_status %0d want %0d", got.st, exp_it.st));
          if (got.last !== exp_it.last)
            report_mismatch($sformatf("line_last %b want %b", got.last, exp_it.last));
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 3) begin
        out_ch.ready <= 1'b0;
        stall_left <= $urandom_range(10, 60);
      end else begin
        out_ch.ready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  // Watchdog over cycles with no accepted request on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[serial_line_editor] ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic test_basic_lines();
    send_str("ab\r\n");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(8'hFF); send_byte(8'h80); send_byte(8'h7E); send_byte(CH_SPACE);
    send_byte(8'h01); send_byte(CH_LF);
  endtask

  task automatic test_editing();
    send_str("abc");
    send_byte(CH_ESC); send_byte(CH_LBRK); send_byte(CH_LEFT);
    send_byte(CH_BS); send_str("X");
    send_byte(CH_ESC); send_byte(CH_LBRK); send_byte(CH_RIGHT);
    send_byte(CH_ESC); send_str("Q");
    send_byte(CH_ESC); send_byte(CH_LBRK); send_str("Z");
    send_byte(CH_DEL);
    send_byte(CH_ESC); send_byte(CH_LBRK); send_byte(CH_CR);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < LSZ + 2; i++) send_byte(8'(8'h41 + i % 26));
    send_byte(CH_CR);
    for (int i = 0; i < LSZ - 1; i++) send_byte(8'(8'h61 + i % 26));
    send_byte(CH_LF);
  endtask

  // Recall walks older past the oldest entry, then steps newer and older in turn.
  task automatic test_history();
    send_str("one\r"); send_str("two\r");
    for (int i = 0; i < 6; i++) begin
      send_byte(CH_ESC); send_byte(CH_LBRK); send_byte(CH_UP);
    end
    for (int i = 0; i < 6; i++) begin
      send_byte(CH_ESC); send_byte(CH_LBRK); send_byte(i[0] ? CH_UP : CH_DOWN);
    end
    send_byte(CH_CR);
  endtask

  task automatic test_raw_prefix();
    write_reg(CFG_RAW_PREFIX, 8'h21);
    send_str("!raw\r");
    send_str("x!\r");
    write_reg(CFG_RAW_PREFIX, 8'hFF);
    send_byte(8'hFF); send_str("q\r");
    send_byte(CH_ESC); send_byte(CH_LBRK); send_byte(CH_UP); send_byte(CH_CR);
  endtask

  task automatic random_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) send_byte(8'($urandom_range(8'h20, 8'h7E)));
    else if (r < 62) send_byte(8'($urandom_range(8'h80, 8'hFF)));
    else if (r < 72) begin
      send_byte(CH_ESC); send_byte(CH_LBRK);
      send_byte(8'(CH_UP + $urandom_range(0, 3)));
    end else if (r < 78) send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
    else if (r < 88) send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    else if (r < 92) send_byte(CH_ESC);
    else send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) random_byte();
    send_byte(CH_CR);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_lines();
    test_editing();
    test_overflow();
    test_history();
    test_raw_prefix();
    write_reg(CFG_HISTORY_SLOTS, 8'd1);
    write_reg(CFG_RAW_PREFIX, 8'($urandom_range(8'h20, 8'h7E)));
    test_random(10);
    // Let everything drain before sending on.
    drain();
    write_reg(CFG_HISTORY_SLOTS, 8'd0);
    test_random(10);
    write_reg(CFG_HISTORY_SLOTS, 8'd7);
    write_reg(CFG_RAW_PREFIX, 8'h00);
    test_random(10);
    write_reg(CFG_HISTORY_SLOTS, 8'd4);
    test_random(10);
    drain();
    if (errors == 0 && expected_items.size() == 0)
      $display("[serial_line_editor] OK");
    else begin
      if (expected_items.size() != 0) report_mismatch("items still expected at end");
      $display("[serial_line_editor] ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/sle_pkg.sv
rtl/core/sle_if.sv
rtl/core/sle_ctrl.sv
rtl/core/sle_dpath.sv
rtl/core/serial_line_editor.sv
test/serial_line_editor_tb.sv
